FILE: hdl/circular_doubly_linked_list_engine_unit_macros.svh
// Assertion macros for the circular doubly linked list engine.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDLL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types and codes for the circular doubly linked list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdll_pkg;

    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int ITEM_DATA_W = 32;
    localparam int COUNT_W     = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_FIRST        = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT         = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV         = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE       = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [ITEM_DATA_W-1:0] data_in;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ITEM_DATA_W-1:0] data_out;
        logic [COUNT_W-1:0]     count;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_req;
        logic issue_rd;
        logic step;
        logic link;
        logic fetch_cap;
        logic load_rsp;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic need_link;
        logic need_fetch;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/circular_doubly_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_engine_unit
// Circular doubly linked list with a cursor over a fixed node pool.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (operation, data_in) and each one yields
// exactly one transaction on the rsp channel (status, data_out, count).
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low.
// One request is worked on at a time. Refused requests and unused codes go from
// read straight to done; insert into an empty list, first and remove add a step
// state; insert into a non-empty list adds a link state, and next and previous
// add a fetch state. The next request can be taken in the cycle after the
// response is loaded.
// A finished response sits in an output register, and the engine accepts the
// next request while it waits. If the receiver stalls longer, a second
// response is held inside until the register is free.
// Reset empties the list, unsets the cursor and refills the free pool at once;
// node memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "circular_doubly_linked_list_engine_unit_macros.svh"

module circular_doubly_linked_list_engine_unit #(
    parameter int ENTRIES    = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire cdll_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output cdll_pkg::rsp_item_t      rsp
);

    import cdll_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cdll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    cdll_datapath #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

    `CDLL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "engine took a second request while busy")
    `CDLL_ASSERT_SAME(a_error_data_zero, rsp_valid && (rsp.status != ST_OK), rsp.data_out == '0, "error response carries data")
    `CDLL_ASSERT_SAME(a_empty_count_zero, rsp_valid && (rsp.status == ST_EMPTY), rsp.count == '0, "empty status with nonzero count")

endmodule

`default_nettype wire

FILE: hdl/cdll_ctrl.sv
// ----------------------------------------------------------------------------
// cdll_ctrl
// Sequencer for one list operation and the response valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdll_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output cdll_pkg::dp_cmd_t       cmd,
    input  wire cdll_pkg::dp_stat_t stat
);

    import cdll_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_STEP  = 6'b000100,
        S_LINK  = 6'b001000,
        S_FETCH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                cmd.issue_rd = 1'b1;
                state_next   = stat.skip ? S_DONE : S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.need_link)
                begin
                    state_next = S_LINK;
                end
                else if (stat.need_fetch)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                cmd.fetch_cap = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/cdll_datapath.sv
// ----------------------------------------------------------------------------
// cdll_datapath
// Node pool memories, free stack, list pointers and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdll_datapath #(
    parameter int ENTRIES    = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cdll_pkg::req_item_t req,
    input  wire cdll_pkg::dp_cmd_t   cmd,
    output cdll_pkg::dp_stat_t       stat,
    output cdll_pkg::rsp_item_t      rsp
);

    import cdll_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Memories.
    logic [DATA_WIDTH-1:0] node_mem [ENTRIES];
    logic [IW-1:0]         next_mem [ENTRIES];
    logic [IW-1:0]         prev_mem [ENTRIES];
    logic [IW-1:0]         fs_mem   [ENTRIES];

    logic [DATA_WIDTH-1:0] node_rd_reg;
    logic [IW-1:0]         next_rd_reg;
    logic [IW-1:0]         prev_rd_reg;
    logic [IW-1:0]         fs_rd_reg;

    // Transaction and list state.
    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] din_reg;
    logic [IW-1:0]         new_reg;
    logic [IW-1:0]         head_reg;
    logic [IW-1:0]         cursor_reg;
    logic                  cur_valid_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         free_reg;
    logic [CW-1:0]         low_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [ITEM_DATA_W-1:0] res_data_reg;
    rsp_item_t             rsp_reg;

    // Decode and derived values.
    logic                  is_ins;
    logic                  is_first;
    logic                  is_step;
    logic                  is_rem;
    logic                  count_zero;
    logic [STATUS_W-1:0]   st_code;
    logic [CW-1:0]         pop_cnt;
    logic [IW-1:0]         new_idx;
    logic [IW-1:0]         link_sel;
    logic [63:0]           din_wide;
    logic [63:0]           node_wide;
    logic [ITEM_DATA_W-1:0] node_out;

    // Memory port controls.
    logic                  node_ren;
    logic [IW-1:0]         node_raddr;
    logic [IW-1:0]         prev_raddr;
    logic [IW-1:0]         fs_raddr;
    logic                  next_we;
    logic [IW-1:0]         next_waddr;
    logic [IW-1:0]         next_wdata;
    logic                  prev_we;
    logic [IW-1:0]         prev_waddr;
    logic [IW-1:0]         prev_wdata;
    logic                  node_we;
    logic                  fs_we;

    assign is_ins     = (op_reg == OP_INSERT_BACK) || (op_reg == OP_INSERT_FRONT);
    assign is_first   = (op_reg == OP_FIRST);
    assign is_step    = (op_reg == OP_NEXT) || (op_reg == OP_PREV);
    assign is_rem     = (op_reg == OP_REMOVE);
    assign count_zero = (count_reg == '0);

    assign din_wide  = 64'(req.data_in);
    assign node_wide = 64'(node_rd_reg);
    assign node_out  = node_wide[ITEM_DATA_W-1:0];

    // Slots below the lowest fill level ever reached were never written; their index stands for their content.
    assign pop_cnt  = free_reg - CW'(1);
    assign fs_raddr = pop_cnt[IW-1:0];
    assign new_idx  = (pop_cnt >= low_reg) ? fs_rd_reg : pop_cnt[IW-1:0];
    assign link_sel = (op_reg == OP_NEXT) ? next_rd_reg : prev_rd_reg;

    always_comb
    begin
        st_code         = ST_OK;
        stat.skip       = 1'b0;
        stat.need_link  = is_ins && !count_zero;
        stat.need_fetch = is_step;
        if (is_ins)
        begin
            if (free_reg == '0)
            begin
                st_code   = ST_FULL;
                stat.skip = 1'b1;
            end
        end
        else if (is_first)
        begin
            if (count_zero)
            begin
                st_code   = ST_EMPTY;
                stat.skip = 1'b1;
            end
        end
        else if (is_step || is_rem)
        begin
            if (count_zero)
            begin
                st_code   = ST_EMPTY;
                stat.skip = 1'b1;
            end
            else if (!cur_valid_reg)
            begin
                st_code   = ST_NOCUR;
                stat.skip = 1'b1;
            end
        end
        else
        begin
            stat.skip = 1'b1;
        end
    end

    // Read side.
    assign node_ren   = cmd.issue_rd || (cmd.step && is_step);
    assign node_raddr = cmd.step ? link_sel : (is_first ? head_reg : cursor_reg);
    assign prev_raddr = is_ins ? head_reg : cursor_reg;

    // Write side.
    assign node_we = cmd.step && is_ins;
    assign fs_we   = cmd.step && is_rem && (free_reg < CW'(ENTRIES));

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = new_idx;
        next_wdata = count_zero ? new_idx : head_reg;
        prev_we    = 1'b0;
        prev_waddr = new_idx;
        prev_wdata = count_zero ? new_idx : prev_rd_reg;
        if (cmd.step && is_ins)
        begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end
        else if (cmd.link)
        begin
            // Splice the new node between the old tail and head.
            next_we    = 1'b1;
            next_waddr = prev_rd_reg;
            next_wdata = new_reg;
            prev_we    = 1'b1;
            prev_waddr = head_reg;
            prev_wdata = new_reg;
        end
        else if (cmd.step && is_rem)
        begin
            next_we    = 1'b1;
            next_waddr = prev_rd_reg;
            next_wdata = next_rd_reg;
            prev_we    = 1'b1;
            prev_waddr = next_rd_reg;
            prev_wdata = prev_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[new_idx] <= din_reg;
        end
        if (node_ren)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.issue_rd)
        begin
            next_rd_reg <= next_mem[cursor_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (cmd.issue_rd)
        begin
            prev_rd_reg <= prev_mem[prev_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[free_reg[IW-1:0]] <= cursor_reg;
        end
        if (cmd.issue_rd)
        begin
            fs_rd_reg <= fs_mem[fs_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            op_reg  <= req.operation;
            din_reg <= din_wide[DATA_WIDTH-1:0];
        end
        if (cmd.step && is_ins)
        begin
            new_reg <= new_idx;
        end
        if (cmd.issue_rd)
        begin
            res_status_reg <= st_code;
            res_data_reg   <= '0;
        end
        else if ((cmd.step && (is_first || is_rem)) || cmd.fetch_cap)
        begin
            res_data_reg <= node_out;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.status   <= res_status_reg;
            rsp_reg.data_out <= res_data_reg;
            rsp_reg.count    <= COUNT_W'(count_reg);
        end
    end

    // List state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cursor_reg    <= '0;
            cur_valid_reg <= 1'b0;
            count_reg     <= '0;
            free_reg      <= CW'(ENTRIES);
            low_reg       <= CW'(ENTRIES);
        end
        else
        begin
            if (cmd.step && is_ins)
            begin
                free_reg  <= pop_cnt;
                low_reg   <= (pop_cnt < low_reg) ? pop_cnt : low_reg;
                count_reg <= count_reg + CW'(1);
                if (count_zero)
                begin
                    head_reg <= new_idx;
                end
            end
            if (cmd.link && (op_reg == OP_INSERT_FRONT))
            begin
                head_reg <= new_reg;
            end
            if (cmd.step && is_first)
            begin
                cursor_reg    <= head_reg;
                cur_valid_reg <= 1'b1;
            end
            if (cmd.step && is_step)
            begin
                cursor_reg <= link_sel;
            end
            if (cmd.step && is_rem)
            begin
                if (count_reg < CW'(2))
                begin
                    count_reg     <= '0;
                    cur_valid_reg <= 1'b0;
                    cursor_reg    <= '0;
                    head_reg      <= '0;
                end
                else
                begin
                    if (cursor_reg == head_reg)
                    begin
                        head_reg <= prev_rd_reg;
                    end
                    cursor_reg <= prev_rd_reg;
                    count_reg  <= count_reg - CW'(1);
                end
                if (free_reg < CW'(ENTRIES))
                begin
                    free_reg <= free_reg + CW'(1);
                end
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: test/tb_circular_doubly_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_circular_doubly_linked_list_engine_unit
// Self-checking testbench for the circular doubly linked list engine.
// ----------------------------------------------------------------------------
// A directed opening covers the empty list, the unset cursor, both inserts,
// every cursor move, the unused operation codes and removal of the last node.
// Random sequences follow: pool fills, drains, cursor walks and noise.
// A shadow list predicts every response. Responses are compared field by field
// in order while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_doubly_linked_list_engine_unit;

    import cdll_pkg::*;

    localparam int POOL_SLOTS   = 16;
    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_PCT     = 21;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;
    localparam int CALM_FROM    = 200;
    localparam int CALM_TO      = 330;

    // Codes outside the defined operations; the engine must ignore them.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    req_item_t pending_reqs[$];
    rsp_item_t awaited_rsps[$];

    // Shadow copy of the list state.
    logic [ITEM_DATA_W-1:0] slot_data[POOL_SLOTS];
    logic [3:0]             next_of[POOL_SLOTS];
    logic [3:0]             prev_of[POOL_SLOTS];
    logic [3:0]             free_slots[POOL_SLOTS];
    logic [4:0]             free_top;
    logic [3:0]             head_slot;
    logic [3:0]             cursor_slot;
    logic                   cursor_set;
    logic [4:0]             list_len;

    int  cyc = 0;
    int  accepted_n = 0;
    int  checked_n = 0;
    int  fault_count = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    int  removals_n = 0;
    logic req_sent = 1'b0;

    wire calm = (accepted_n >= CALM_FROM) && (accepted_n < CALM_TO);

    circular_doubly_linked_list_engine_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_shadow_list();
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            slot_data[i]  = '0;
            next_of[i]    = '0;
            prev_of[i]    = '0;
            free_slots[i] = i[3:0];
        end
        free_top    = 5'(POOL_SLOTS);
        head_slot   = '0;
        cursor_slot = '0;
        cursor_set  = 1'b0;
        list_len    = '0;
    endfunction

    function automatic rsp_item_t predict_list_op(req_item_t r);
        rsp_item_t  o;
        logic [3:0] n;
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] p;
        logic [3:0] nx;
        o.status   = ST_OK;
        o.data_out = '0;
        case (r.operation)
            OP_INSERT_BACK, OP_INSERT_FRONT:
            begin
                if (free_top == 0)
                    o.status = ST_FULL;
                else
                begin
                    free_top--;
                    n = free_slots[free_top];
                    slot_data[n] = r.data_in;
                    if (list_len == 0)
                    begin
                        next_of[n] = n;
                        prev_of[n] = n;
                        head_slot  = n;
                    end
                    else
                    begin
                        // The new node always goes between tail and head.
                        h = head_slot;
                        t = prev_of[h];
                        next_of[n] = h;
                        prev_of[n] = t;
                        next_of[t] = n;
                        prev_of[h] = n;
                        if (r.operation == OP_INSERT_FRONT)
                            head_slot = n;
                    end
                    list_len++;
                end
            end
            OP_FIRST:
            begin
                if (list_len == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    cursor_slot = head_slot;
                    cursor_set  = 1'b1;
                    o.data_out  = slot_data[cursor_slot];
                end
            end
            OP_NEXT, OP_PREV, OP_REMOVE:
            begin
                if (list_len == 0)
                    o.status = ST_EMPTY;
                else if (!cursor_set)
                    o.status = ST_NOCUR;
                else if (r.operation == OP_REMOVE)
                begin
                    n  = cursor_slot;
                    p  = prev_of[n];
                    nx = next_of[n];
                    o.data_out = slot_data[n];
                    if (list_len <= 1)
                    begin
                        list_len    = '0;
                        cursor_set  = 1'b0;
                        cursor_slot = '0;
                        head_slot   = '0;
                    end
                    else
                    begin
                        if (n == head_slot)
                            head_slot = p;
                        next_of[p]  = nx;
                        prev_of[nx] = p;
                        cursor_slot = p;
                        list_len--;
                    end
                    if (free_top < POOL_SLOTS)
                    begin
                        free_slots[free_top] = n;
                        free_top++;
                    end
                end
                else
                begin
                    cursor_slot = (r.operation == OP_NEXT) ? next_of[cursor_slot]
                                                           : prev_of[cursor_slot];
                    o.data_out  = slot_data[cursor_slot];
                end
            end
            default:
            begin
            end
        endcase
        o.count = list_len;
        return o;
    endfunction

    function automatic void queue_req(logic [OP_W-1:0] op, logic [ITEM_DATA_W-1:0] d);
        req_item_t r;
        r.operation = op;
        r.data_in   = d;
        pending_reqs.push_back(r);
    endfunction

    // Mostly uniform words, with the all-zero and all-one extremes mixed in.
    function automatic logic [ITEM_DATA_W-1:0] pick_word();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_insert();
        return $urandom_range(0, 1) ? OP_INSERT_FRONT : OP_INSERT_BACK;
    endfunction

    task automatic check_response(rsp_item_t got);
        rsp_item_t want;
        if (awaited_rsps.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("[%0t] response with none pending: status %0d data %h count %0d",
                         $realtime, got.status, got.data_out, got.count);
        end
        else
        begin
            want = awaited_rsps.pop_front();
            checked_n++;
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.count !== want.count)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("[%0t] response %0d: status %0d/%0d data %h/%h count %0d/%0d %s",
                             $realtime, checked_n, want.status, got.status,
                             want.data_out, got.data_out, want.count, got.count,
                             "(expected/actual)");
            end
        end
    endtask

    // Requests are predicted as they are taken; responses are checked as they
    // leave the engine.
    always @(posedge clk)
    begin
        rsp_item_t e;
        cyc <= cyc + 1;
        req_sent <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
        begin
            e = predict_list_op(req);
            awaited_rsps.push_back(e);
            status_seen[e.status]++;
            if (req.operation == OP_REMOVE && e.status == ST_OK)
                removals_n++;
            accepted_n++;
        end
        if (rst_n && rsp_valid && !rsp_stall)
            check_response(rsp);
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_sent)
            begin
                if (pending_reqs.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        while (cyc < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int pick;
        int len;
        int k;
        int total;
        reset_shadow_list();

        // Empty list, then an unset cursor, then moves over two nodes.
        queue_req(OP_REMOVE, pick_word());
        queue_req(OP_NEXT, pick_word());
        queue_req(OP_PREV, pick_word());
        queue_req(OP_FIRST, pick_word());
        queue_req(OP_INSERT_BACK, '0);
        queue_req(OP_INSERT_FRONT, '1);
        queue_req(OP_NEXT, pick_word());
        queue_req(OP_PREV, pick_word());
        queue_req(OP_REMOVE, pick_word());
        queue_req(OP_FIRST, pick_word());
        queue_req(OP_NEXT, pick_word());
        queue_req(OP_PREV, pick_word());
        queue_req(OP_SPARE_A, '1);
        queue_req(OP_SPARE_B, '0);
        queue_req(OP_INSERT_BACK, 32'hA5A5_A5A5);
        // Removing head moves head and cursor back; the last removal empties.
        queue_req(OP_REMOVE, '0);
        queue_req(OP_REMOVE, '0);
        queue_req(OP_REMOVE, '0);
        queue_req(OP_NEXT, '0);
        queue_req(OP_INSERT_BACK, 32'h5A5A_5A5A);
        queue_req(OP_NEXT, '0);
        queue_req(OP_FIRST, '0);

        total = pending_reqs.size() + RANDOM_ITEMS;
        while (pending_reqs.size() < total)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // More inserts than slots, so the pool always ends up full.
                repeat (POOL_SLOTS + 2)
                    queue_req(pick_insert(), pick_word());
            end
            else if (pick < 30)
            begin
                queue_req(OP_FIRST, pick_word());
                repeat (POOL_SLOTS + 2)
                begin
                    k = $urandom_range(0, 9);
                    if (k < 8)
                        queue_req(OP_REMOVE, pick_word());
                    else
                        queue_req(k == 8 ? OP_NEXT : OP_PREV, pick_word());
                end
            end
            else if (pick < 75)
            begin
                queue_req(OP_FIRST, pick_word());
                len = $urandom_range(4, 14);
                repeat (len)
                begin
                    k = $urandom_range(0, 9);
                    if (k < 4)
                        queue_req(OP_NEXT, pick_word());
                    else if (k < 7)
                        queue_req(OP_PREV, pick_word());
                    else if (k < 8)
                        queue_req(OP_REMOVE, pick_word());
                    else
                        queue_req(pick_insert(), pick_word());
                end
            end
            else
            begin
                len = $urandom_range(2, 8);
                repeat (len)
                    queue_req(3'($urandom_range(0, 7)), pick_word());
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Took %0d requests and checked %0d responses, %0d removals.",
                 accepted_n, checked_n, removals_n);
        $display("Refusals seen: %0d empty list, %0d pool full, %0d cursor unset.",
                 status_seen[ST_EMPTY], status_seen[ST_FULL], status_seen[ST_NOCUR]);
        if (fault_count == 0 && awaited_rsps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
